@@ design/tpp_pkg.sv @@
// Shared types, constants and coefficient table of the piecewise tanh core.
package tpp_pkg;

  // Fixed field widths and internal formats
  localparam int X_WIDTH       = 24;  // argument field
  localparam int POLY_FRAC     = 28;  // internal Q3.28 fraction bits
  localparam int YW            = 32;  // clamped argument, at most 8.0 in Q28
  localparam int AW            = 32;  // Horner accumulator, |acc| < 2^30
  localparam int PW            = YW + AW + 1;  // signed product of y and acc
  localparam int RW            = POLY_FRAC + 1;  // saturated result, 0 .. 1.0
  localparam int NUM_STEPS     = 5;   // Horner steps per item
  localparam int DEF_IN_FRAC   = 20;
  localparam int DEF_OUT_FRAC  = 22;

  // Segment of the argument range
  typedef enum logic [1:0] {
    SEG_UNIT,  // y < 1
    SEG_TWO,   // 1 <= y < 2
    SEG_FOUR,  // 2 <= y < 4
    SEG_TAIL   // 4 <= y <= 8
  } tpp_seg_t;

  // One item travelling down the Horner chain
  typedef struct packed {
    logic [YW-1:0]        y;
    tpp_seg_t             seg;
    logic signed [AW-1:0] acc;
  } tpp_beat_t;

  // Polynomial coefficients in Q28, index k is the power of y
  function automatic logic signed [AW-1:0] seg_coef(input tpp_seg_t seg,
                                                    input logic [2:0] k);
    logic signed [AW-1:0] c;
    c = '0;
    unique case (seg)
      SEG_UNIT: begin
        case (k)
          3'd0:    c = 32'sd0;
          3'd1:    c = 32'sd268402688;
          3'd2:    c = 32'sd1528035;
          3'd3:    c = -32'sd101656512;
          3'd4:    c = 32'sd33379832;
          3'd5:    c = 32'sd2813220;
          default: c = '0;
        endcase
      end
      SEG_TWO: begin
        case (k)
          3'd0:    c = -32'sd33554432;
          3'd1:    c = 32'sd406901376;
          3'd2:    c = -32'sd217620640;
          3'd3:    c = 32'sd53804128;
          3'd4:    c = -32'sd5088159;
          default: c = '0;
        endcase
      end
      SEG_FOUR: begin
        case (k)
          3'd0:    c = 32'sd16777216;
          3'd1:    c = 32'sd325452544;
          3'd2:    c = -32'sd173957088;
          3'd3:    c = 32'sd47664368;
          3'd4:    c = -32'sd6651712;
          3'd5:    c = 32'sd376273;
          default: c = '0;
        endcase
      end
      SEG_TAIL: begin
        case (k)
          3'd0:    c = 32'sd268435456;
          3'd1:    c = -32'sd743792;
          3'd2:    c = 32'sd341428;
          3'd3:    c = -32'sd51679;
          3'd4:    c = 32'sd2580;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ design/tpp_front.sv @@
// Front stage: clamp the argument, rescale to Q28, pick segment and leading coefficient.
module tpp_front #(
  parameter int IN_FRAC_BITS = tpp_pkg::DEF_IN_FRAC
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [tpp_pkg::X_WIDTH-1:0]  x_value,
  output logic                         out_valid,
  output tpp_pkg::tpp_beat_t           out_beat
);
  import tpp_pkg::*;

  localparam int            Y_SH    = POLY_FRAC - IN_FRAC_BITS;
  localparam logic [YW-1:0] X_LIMIT = YW'(8) << IN_FRAC_BITS;
  localparam logic [YW-1:0] Y_ONE   = YW'(1) << POLY_FRAC;

  logic        valid_r;
  tpp_beat_t   beat_r, beat_nxt;
  logic [YW-1:0] x_ext, x_clamp;

  // clamp to 8.0 and align to the internal format
  always_comb begin
    x_ext        = YW'(x_value);
    x_clamp      = (x_ext > X_LIMIT) ? X_LIMIT : x_ext;
    beat_nxt.y   = x_clamp << Y_SH;
    if (beat_nxt.y < Y_ONE) begin
      beat_nxt.seg = SEG_UNIT;
    end else if (beat_nxt.y < (Y_ONE << 1)) begin
      beat_nxt.seg = SEG_TWO;
    end else if (beat_nxt.y < (Y_ONE << 2)) begin
      beat_nxt.seg = SEG_FOUR;
    end else begin
      beat_nxt.seg = SEG_TAIL;
    end
    beat_nxt.acc = seg_coef(beat_nxt.seg, 3'd5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

@@ design/tpp_horner_step.sv @@
// One Horner step over two stages: multiply by y, then round, shift and add coefficient.
module tpp_horner_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [2:0]           coef_k,
  input  logic                 in_valid,
  input  tpp_pkg::tpp_beat_t   in_beat,
  output logic                 out_valid,
  output tpp_pkg::tpp_beat_t   out_beat
);
  import tpp_pkg::*;

  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (POLY_FRAC - 1);

  logic                  mul_valid_r;
  tpp_beat_t             mul_beat_r;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic                  add_valid_r;
  tpp_beat_t             add_beat_r, add_beat_nxt;
  logic signed [PW-1:0]  rounded;

  // multiply stage
  assign prod_nxt = $signed({1'b0, in_beat.y}) * in_beat.acc;

  // add stage: floor((y*acc + half) / 2^28) + a_k
  always_comb begin
    rounded          = (prod_r + HALF) >>> POLY_FRAC;
    add_beat_nxt     = mul_beat_r;
    add_beat_nxt.acc = seg_coef(mul_beat_r.seg, coef_k) + $signed(rounded[AW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      add_valid_r <= 1'b0;
    end else if (adv) begin
      mul_valid_r <= in_valid;
      add_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_beat_r <= in_beat;
      prod_r     <= prod_nxt;
      add_beat_r <= add_beat_nxt;
    end
  end

  assign out_valid = add_valid_r;
  assign out_beat  = add_beat_r;

endmodule

@@ design/tpp_out_stage.sv @@
// Output register: saturate to [0, 1.0], then round (or widen) to the output format.
module tpp_out_stage #(
  parameter int OUT_FRAC_BITS = tpp_pkg::DEF_OUT_FRAC
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [tpp_pkg::AW-1:0] acc,
  output logic                          out_valid,
  output logic [OUT_FRAC_BITS:0]        tanh_value
);
  import tpp_pkg::*;

  localparam int                   OW      = OUT_FRAC_BITS + 1;
  localparam logic signed [AW-1:0] ACC_ONE = AW'(1) <<< POLY_FRAC;

  logic          valid_r;
  logic [OW-1:0] tanh_r, tanh_nxt;
  logic [RW-1:0] sat;

  // saturate
  always_comb begin
    if (acc < 0) begin
      sat = '0;
    end else if (acc > ACC_ONE) begin
      sat = ACC_ONE[RW-1:0];
    end else begin
      sat = acc[RW-1:0];
    end
  end

  // rescale to the output fraction width
  if (OUT_FRAC_BITS >= POLY_FRAC) begin : g_widen
    assign tanh_nxt = OW'(sat) << (OUT_FRAC_BITS - POLY_FRAC);
  end else begin : g_round
    localparam int            SH   = POLY_FRAC - OUT_FRAC_BITS;
    localparam logic [RW-1:0] HALF = RW'(1) << (SH - 1);
    logic [RW-1:0] sum;
    assign sum      = sat + HALF;
    assign tanh_nxt = OW'(sum >> SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tanh_r <= tanh_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign tanh_value = tanh_r;

endmodule

@@ design/tanh_piecewise_poly_core.sv @@
// Top level of the piecewise polynomial tanh core.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tdata[23:0] x_value, unsigned Q4.20 by default
//  out_    | master    | tdata[OUT_FRAC_BITS:0] tanh_value, Q1.OUT_FRAC_BITS
//
//  One beat in and one beat out per cycle while the output is not stalled;
//  the pipeline stages are the front clamp stage, two stages for each of the
//  five Horner multiply/add steps, and the saturating output register.
//  Reset clears only the valid bits of the stages.
//  The whole pipeline holds while the output register is full and not taken;
//  in_tready follows that condition, so no beat is dropped or repeated.
module tanh_piecewise_poly_core #(
  parameter int IN_FRAC_BITS  = tpp_pkg::DEF_IN_FRAC,
  parameter int OUT_FRAC_BITS = tpp_pkg::DEF_OUT_FRAC
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [23:0]                          in_tdata,   // [23:0] x_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((OUT_FRAC_BITS + 8) / 8) * 8 - 1:0] out_tdata // [OUT_FRAC_BITS:0] tanh_value
);
  import tpp_pkg::*;

  localparam int                OW     = OUT_FRAC_BITS + 1;
  localparam int                ODW    = ((OUT_FRAC_BITS + 8) / 8) * 8;
  localparam logic [OW-1:0]     O_ONE  = OW'(1) << OUT_FRAC_BITS;
  localparam logic [YW-1:0]     Y_ONE  = YW'(1) << POLY_FRAC;

  logic                   adv;
  logic                   front_valid;
  tpp_beat_t              front_beat;
  logic [NUM_STEPS:0]     step_valid;
  tpp_beat_t              step_beat [NUM_STEPS+1];
  logic [OW-1:0]          tanh_value;

  // pipeline advances unless a finished beat is stuck at the output
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  tpp_front #(
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .x_value   (in_tdata[X_WIDTH-1:0]),
    .out_valid (front_valid),
    .out_beat  (front_beat)
  );

  assign step_valid[0] = front_valid;
  assign step_beat[0]  = front_beat;

  // Horner chain, coefficients a4 down to a0
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    tpp_horner_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .coef_k    (3'(NUM_STEPS - 1 - i)),
      .in_valid  (step_valid[i]),
      .in_beat   (step_beat[i]),
      .out_valid (step_valid[i+1]),
      .out_beat  (step_beat[i+1])
    );
  end

  tpp_out_stage #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (step_valid[NUM_STEPS]),
    .acc        (step_beat[NUM_STEPS].acc),
    .out_valid  (out_tvalid),
    .tanh_value (tanh_value)
  );

  assign out_tdata = ODW'(tanh_value);

  // result never exceeds 1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> tanh_value <= O_ONE)
    else $error("tanh result above 1.0");

  // chosen segment agrees with the clamped argument
  a_seg_match: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid |-> ((front_beat.seg == SEG_TAIL) == (front_beat.y >= (Y_ONE << 2)))
                 && ((front_beat.seg == SEG_UNIT) == (front_beat.y < Y_ONE)))
    else $error("segment does not match argument");

  // argument never beyond 8.0 after clamping
  a_y_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid |-> front_beat.y <= (Y_ONE << 3))
    else $error("clamped argument above 8.0");

  // a held pipeline keeps the valid bits at the step outputs and at the output in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(step_valid) && $stable(out_tvalid))
    else $error("valid bits moved during a stall");

endmodule
